// File: sv/slc_pkg.sv
// Shared types and constants for the set-associative LRU cache tag unit.
// No dependencies; imported by slc_ctrl, slc_dp and set_assoc_lru_cache_tags_unit.
package slc_pkg;

    // Geometry. MAX_SETS is taken to be a power of two (set index wraps by masking).
    localparam int MAX_SETS = 64;
    localparam int MAX_WAYS = 8;
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYCNT_W = $clog2(MAX_WAYS + 1);

    localparam int ADDR_W   = 64;
    // Tag kept at full address width: with zero offset and set bits it is the whole address
    localparam int TAG_W    = ADDR_W;
    localparam int STAMP_W  = 64;
    localparam int CNT_W    = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_BAD    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2,
        OUT_BAD   = 2'd3
    } outcome_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        outcome_t         outcome;
        logic             last;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] evict_total;
    } rsp_t;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [STAMP_W-1:0]  stamp;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] row_t;

    // Controller to datapath commands
    typedef struct packed {
        logic lookup;    // latch item, read its set row
        logic emit_bad;  // issue bad-operation result
        logic eval;      // compare, choose way, write back, issue result
        logic fwd;       // use the row just written instead of the memory read
        logic last;      // result is the final one of the item
    } ctrl_cmd_t;

endpackage

// File: sv/slc_ctrl.sv
// Sequencer for the cache tag unit: accepts items and steps the datapath
// through one or two accesses (none for a bad operation). Depends on slc_pkg.
module slc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  slc_pkg::op_t        op,
    output logic                busy,
    output slc_pkg::ctrl_cmd_t  cmd
);
    import slc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EVAL_A = 3'b010,
        S_EVAL_B = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   mod_reg;
    logic   mod_next;

    always_comb
    begin
        state_next = state_reg;
        mod_next   = mod_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_BAD)
                    begin
                        cmd.emit_bad = 1'b1;
                    end
                    else
                    begin
                        cmd.lookup = 1'b1;
                        mod_next   = (op == OP_MODIFY);
                        state_next = S_EVAL_A;
                    end
                end
            end
            S_EVAL_A:
            begin
                cmd.eval   = 1'b1;
                cmd.last   = !mod_reg;
                state_next = mod_reg ? S_EVAL_B : S_IDLE;
            end
            S_EVAL_B:
            begin
                // store half of a modify, same set as the load before it
                cmd.eval   = 1'b1;
                cmd.fwd    = 1'b1;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mod_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mod_reg   <= mod_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_lookup_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> (cmd.eval && !cmd.fwd))
        else $error("lookup not followed by evaluation");

    a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL_B) |-> $past(state_reg == S_EVAL_A && mod_reg))
        else $error("second access without a modify load before it");

    a_one_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.eval && (cmd.lookup || cmd.emit_bad)))
        else $error("evaluation overlaps an item being taken");

endmodule

// File: sv/slc_dp.sv
// Datapath of the cache tag unit: config registers, set-row memory,
// hit/fill/victim selection, timestamp and saturating totals. Depends on slc_pkg.
module slc_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  slc_pkg::ctrl_cmd_t                     cmd,
    input  slc_pkg::req_t                          req,
    input  logic                                   cfg_write,
    input  logic [slc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic                                   done,
    output slc_pkg::rsp_t                          rsp
);
    import slc_pkg::*;

    localparam int LEAVES  = 1 << WAY_W;
    localparam int SHAMT_W = 7;

    // config
    logic [2:0] set_bits_reg;
    logic [5:0] block_bits_reg;
    logic [3:0] ways_reg;

    // set row memory, plus one flag per set: a row never written reads as all invalid
    row_t               mem [MAX_SETS];
    row_t               rdata_reg;
    row_t               upd_reg;
    logic [MAX_SETS-1:0] row_init_reg;
    logic               init_reg;

    logic [SET_W-1:0]   set_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [STAMP_W-1:0] counter_reg;
    logic [CNT_W-1:0]   hit_reg;
    logic [CNT_W-1:0]   miss_reg;
    logic [CNT_W-1:0]   evict_reg;
    rsp_t               rsp_reg;
    logic               done_reg;

    // address split
    logic [ADDR_W-1:0]  shifted;
    logic [SET_W-1:0]   set_mask;
    logic [SET_W-1:0]   set_next;
    logic [SHAMT_W-1:0] shamt;
    logic [TAG_W-1:0]   tag_next;

    always_comb
    begin
        shifted = req.address >> block_bits_reg;
        for (int i = 0; i < SET_W; i++)
        begin
            set_mask[i] = (i < int'(set_bits_reg));
        end
        set_next = shifted[SET_W-1:0] & set_mask;
        shamt    = SHAMT_W'(set_bits_reg) + SHAMT_W'(block_bits_reg);
        tag_next = (shamt >= SHAMT_W'(ADDR_W)) ? '0 : (req.address >> shamt[5:0]);
    end

    // way lookup
    logic [WAYCNT_W-1:0] ways_eff;
    row_t                cur_row;
    logic [MAX_WAYS-1:0] en;
    logic [MAX_WAYS-1:0] vraw;
    logic [MAX_WAYS-1:0] hit;
    logic [MAX_WAYS-1:0] empty;
    logic [WAY_W-1:0]    hit_idx;
    logic [WAY_W-1:0]    empty_idx;
    logic [WAY_W-1:0]    victim_idx;
    logic [WAY_W-1:0]    tgt_idx;
    outcome_t            outcome_next;
    row_t                upd_next;

    logic [WAY_W-1:0]   t_idx   [WAY_W+1][LEAVES];
    logic [STAMP_W-1:0] t_stamp [WAY_W+1][LEAVES];
    logic               t_en    [WAY_W+1][LEAVES];

    always_comb
    begin
        if (ways_reg == 4'd0)
        begin
            ways_eff = WAYCNT_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WAYCNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAYCNT_W'(ways_reg);
        end
    end

    always_comb
    begin
        cur_row   = cmd.fwd ? upd_reg : rdata_reg;
        hit_idx   = '0;
        empty_idx = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            en[w]    = (WAYCNT_W'(w) < ways_eff);
            vraw[w]  = cur_row[w].valid & (cmd.fwd | init_reg);
            hit[w]   = en[w] & vraw[w] & (cur_row[w].tag == tag_reg);
            empty[w] = en[w] & ~vraw[w];
        end
        // lowest-numbered way wins
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit[w])
            begin
                hit_idx = WAY_W'(w);
            end
            if (empty[w])
            begin
                empty_idx = WAY_W'(w);
            end
        end
    end

    // oldest stamp among ways in use; ties go to the lower way
    always_comb
    begin
        for (int l = 0; l <= WAY_W; l++)
        begin
            for (int i = 0; i < LEAVES; i++)
            begin
                t_idx[l][i]   = '0;
                t_stamp[l][i] = '0;
                t_en[l][i]    = 1'b0;
            end
        end
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            t_idx[0][i]   = WAY_W'(i);
            t_stamp[0][i] = cur_row[i].stamp;
            t_en[0][i]    = en[i];
        end
        for (int l = 0; l < WAY_W; l++)
        begin
            for (int i = 0; i < (LEAVES >> (l + 1)); i++)
            begin
                if (t_en[l][2*i+1] &&
                    (!t_en[l][2*i] || (t_stamp[l][2*i+1] < t_stamp[l][2*i])))
                begin
                    t_idx[l+1][i]   = t_idx[l][2*i+1];
                    t_stamp[l+1][i] = t_stamp[l][2*i+1];
                end
                else
                begin
                    t_idx[l+1][i]   = t_idx[l][2*i];
                    t_stamp[l+1][i] = t_stamp[l][2*i];
                end
                t_en[l+1][i] = t_en[l][2*i] | t_en[l][2*i+1];
            end
        end
        victim_idx = t_idx[WAY_W][0];
    end

    // totals after this access
    logic [CNT_W-1:0] hit_next;
    logic [CNT_W-1:0] miss_next;
    logic [CNT_W-1:0] evict_next;

    always_comb
    begin
        upd_next = cur_row;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            upd_next[w].valid = vraw[w];
        end
        hit_next   = hit_reg;
        miss_next  = miss_reg;
        evict_next = evict_reg;
        if (|hit)
        begin
            tgt_idx      = hit_idx;
            outcome_next = OUT_HIT;
            hit_next     = (hit_reg == '1) ? hit_reg : hit_reg + 1'b1;
        end
        else if (|empty)
        begin
            tgt_idx      = empty_idx;
            outcome_next = OUT_FILL;
            miss_next    = (miss_reg == '1) ? miss_reg : miss_reg + 1'b1;
        end
        else
        begin
            tgt_idx      = victim_idx;
            outcome_next = OUT_EVICT;
            miss_next    = (miss_reg == '1) ? miss_reg : miss_reg + 1'b1;
            evict_next   = (evict_reg == '1) ? evict_reg : evict_reg + 1'b1;
        end
        upd_next[tgt_idx].valid = 1'b1;
        upd_next[tgt_idx].tag   = tag_reg;
        upd_next[tgt_idx].stamp = counter_reg;
    end

    // config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 3'd1;
            block_bits_reg <= 6'd1;
            ways_reg       <= 4'd1;
            row_init_reg   <= '0;
            counter_reg    <= '0;
            hit_reg        <= '0;
            miss_reg       <= '0;
            evict_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SET_BITS:    set_bits_reg   <= cfg_data[2:0];
                    REG_BLOCK_BITS:  block_bits_reg <= cfg_data;
                    REG_WAYS_IN_USE: ways_reg       <= cfg_data[3:0];
                    default:         ;
                endcase
            end
            if (cmd.eval)
            begin
                row_init_reg[set_reg] <= 1'b1;
                counter_reg           <= counter_reg + 1'b1;
                hit_reg               <= hit_next;
                miss_reg              <= miss_next;
                evict_reg             <= evict_next;
            end
            done_reg <= cmd.eval | cmd.emit_bad;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            set_reg  <= set_next;
            tag_reg  <= tag_next;
            init_reg <= row_init_reg[set_next];
        end
        if (cmd.eval)
        begin
            upd_reg             <= upd_next;
            rsp_reg.outcome     <= outcome_next;
            rsp_reg.last        <= cmd.last;
            rsp_reg.hit_total   <= hit_next;
            rsp_reg.miss_total  <= miss_next;
            rsp_reg.evict_total <= evict_next;
        end
        else if (cmd.emit_bad)
        begin
            rsp_reg.outcome     <= OUT_BAD;
            rsp_reg.last        <= 1'b1;
            rsp_reg.hit_total   <= hit_reg;
            rsp_reg.miss_total  <= miss_reg;
            rsp_reg.evict_total <= evict_reg;
        end
    end

    // row memory
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            mem[set_reg] <= upd_next;
        end
        if (cmd.lookup)
        begin
            rdata_reg <= mem[set_next];
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_store_half_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval && cmd.fwd) |=> (rsp_reg.outcome == OUT_HIT))
        else $error("second access of a modify missed");

    a_bad_keeps_totals: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_bad |=> ($stable(hit_reg) && $stable(miss_reg) && $stable(evict_reg)
                          && $stable(counter_reg)))
        else $error("bad operation changed state");

endmodule

// File: sv/set_assoc_lru_cache_tags_unit.sv
// Set-associative tag store with LRU replacement: top level.
// Depends on slc_pkg, slc_ctrl and slc_dp.
//
// An item is taken when start is high and busy low. For a load or store, the
// set row is read from the row memory in the cycle the item is taken,
// and in the next cycle the ways are compared, the way to fill or evict is chosen
// and the row is written back. A modify then makes a second access, its store,
// which reuses the row just written; a bad operation makes no access. Each result
// shows on rsp for one cycle with done high, the cycle after it is worked out,
// and must be captured then: there is no way to hold it off. No clearing pass is
// needed after reset; a per-set flag marks rows that have never been written.
module set_assoc_lru_cache_tags_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  slc_pkg::req_t                      req,
    input  logic                               cfg_write,
    input  logic [slc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               done,
    output slc_pkg::rsp_t                      rsp
);
    import slc_pkg::*;

    ctrl_cmd_t cmd;

    slc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (req.op),
        .busy  (busy),
        .cmd   (cmd)
    );

    slc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for set_assoc_lru_cache_tags_unit (LRU tag store).
// Depends on slc_pkg and the RTL; a scoreboard class predicts the outcome and
// running totals of every access, and tasks drive the command and register ports.
module tb_top;
    import slc_pkg::*;

    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int ITEMS_PER_SETTING = 195;
    localparam int N_SETTINGS        = 9;

    class lru_tag_checker;
        bit          line_valid [MAX_SETS*MAX_WAYS];
        logic [63:0] line_tag   [MAX_SETS*MAX_WAYS];
        logic [63:0] line_stamp [MAX_SETS*MAX_WAYS];
        logic [63:0] access_count;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
        logic [2:0]  set_bits;
        logic [5:0]  block_bits;
        logic [3:0]  ways_in_use;
        rsp_t        expected_results[$];
        int          errors;
        int          outcome_seen[4];

        function new();
            access_count = '0;
            hits         = '0;
            misses       = '0;
            evictions    = '0;
            set_bits     = 3'd1;
            block_bits   = 6'd1;
            ways_in_use  = 4'd1;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SET_BITS:    set_bits    = val[2:0];
                REG_BLOCK_BITS:  block_bits  = val[5:0];
                REG_WAYS_IN_USE: ways_in_use = val[3:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == '1) ? v : v + 32'd1;
        endfunction

        // One lookup in a set: refresh on hit, else fill lowest empty way or evict oldest
        function outcome_t touch_line(logic [63:0] tg, int set_i, logic [63:0] stamp);
            int nways;
            int base;
            int victim;
            bit have_victim;
            nways = (ways_in_use == 0) ? 1 :
                    ((ways_in_use > MAX_WAYS) ? MAX_WAYS : int'(ways_in_use));
            base = set_i * MAX_WAYS;
            victim = 0;
            have_victim = 1'b0;
            for (int w = 0; w < nways; w++) begin
                if (line_valid[base+w] && line_tag[base+w] == tg) begin
                    line_stamp[base+w] = stamp;
                    hits = bump(hits);
                    return OUT_HIT;
                end
            end
            misses = bump(misses);
            for (int w = 0; w < nways; w++) begin
                if (!line_valid[base+w]) begin
                    line_valid[base+w] = 1'b1;
                    line_tag[base+w]   = tg;
                    line_stamp[base+w] = stamp;
                    return OUT_FILL;
                end
                if (!have_victim || line_stamp[base+w] < line_stamp[base+victim]) begin
                    victim = w;
                    have_victim = 1'b1;
                end
            end
            line_tag[base+victim]   = tg;
            line_stamp[base+victim] = stamp;
            evictions = bump(evictions);
            return OUT_EVICT;
        endfunction

        function void add_expected(outcome_t o, logic is_last);
            rsp_t r;
            r.outcome     = o;
            r.last        = is_last;
            r.hit_total   = hits;
            r.miss_total  = misses;
            r.evict_total = evictions;
            expected_results.push_back(r);
        endfunction

        function void note_access(req_t item);
            int shift;
            int set_i;
            logic [63:0] tg;
            outcome_t o;
            shift = int'(set_bits) + int'(block_bits);
            tg = (shift >= 64) ? 64'd0 : (item.address >> shift);
            set_i = int'(((item.address >> block_bits) & ((64'd1 << set_bits) - 64'd1))
                         % MAX_SETS);
            case (item.op)
                OP_BAD: add_expected(OUT_BAD, 1'b1);
                OP_MODIFY:
                begin
                    // load then store to the same line; the store cannot miss
                    o = touch_line(tg, set_i, access_count);
                    add_expected(o, 1'b0);
                    o = touch_line(tg, set_i, access_count + 64'd1);
                    add_expected(o, 1'b1);
                    access_count += 64'd2;
                end
                default:
                begin
                    o = touch_line(tg, set_i, access_count);
                    add_expected(o, 1'b1);
                    access_count += 64'd1;
                end
            endcase
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: outcome=%0d last=%0d hit=%0d miss=%0d evict=%0d",
                         $time, got.outcome, got.last, got.hit_total, got.miss_total,
                         got.evict_total);
                return;
            end
            want = expected_results.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch: expected outcome=%0d last=%0d hit=%0d miss=%0d evict=%0d",
                         $time, want.outcome, want.last, want.hit_total, want.miss_total,
                         want.evict_total);
                $display("%0t:           actual outcome=%0d last=%0d hit=%0d miss=%0d evict=%0d",
                         $time, got.outcome, got.last, got.hit_total, got.miss_total,
                         got.evict_total);
            end
            else begin
                outcome_seen[int'(got.outcome)]++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    req_t                  req;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    rsp_t                  rsp;

    lru_tag_checker chk;
    int idle_cycles;
    int items_accepted;
    int sender_idle_pct;
    int settings_run;
    int cur_sb;
    int cur_bb;
    int cur_ways;

    // Geometries: reset values, legal extremes, and field extremes (tag shifted out,
    // set index aliasing above MAX_SETS, way counts of zero and above MAX_WAYS)
    int geo_sb   [N_SETTINGS] = '{1, 2, 6, 0, 7, 3, 1, 6, 5};
    int geo_bb   [N_SETTINGS] = '{1, 4, 32, 0, 63, 5, 1, 58, 6};
    int geo_ways [N_SETTINGS] = '{1, 4, 8, 0, 15, 2, 8, 8, 3};

    set_assoc_lru_cache_tags_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor and watchdog: sample at the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            idle_cycles++;
            if (start && !busy) begin
                chk.note_access(req);
                items_accepted++;
                idle_cycles = 0;
            end
            if (done) begin
                chk.check_result(rsp);
                idle_cycles = 0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         chk.expected_results.size());
                $display("tb_top failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val[CFG_DATA_W-1:0];
        chk.write_reg(idx, val[CFG_DATA_W-1:0]);
    endtask

    task automatic set_geometry(int sb, int bb, int ways);
        write_reg(REG_SET_BITS, sb);
        write_reg(REG_BLOCK_BITS, bb);
        write_reg(REG_WAYS_IN_USE, ways);
        @(negedge clk);
        cfg_write = 1'b0;
        cur_sb   = sb;
        cur_bb   = bb;
        cur_ways = ways;
        settings_run++;
    endtask

    // Present one item and hold it until taken
    task automatic send(op_t op, logic [63:0] addr);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start       = 1'b1;
        req.op      = op;
        req.address = addr;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Block must be idle before a register write
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (chk.expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [63:0] make_addr(int unsigned tg, int unsigned set_i,
                                              logic [63:0] off);
        logic [63:0] off_mask;
        off_mask = (64'd1 << cur_bb) - 64'd1;
        return (64'(tg) << (cur_sb + cur_bb)) | (64'(set_i) << cur_bb) | (off & off_mask);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_run(int count);
        int nways;
        int set_max;
        int r;
        int unsigned tg;
        int unsigned set_i;
        op_t op;
        logic [63:0] addr;
        nways = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways);
        set_max = (1 << cur_sb) - 1;
        for (int k = 0; k < count; k++) begin
            sender_idle_pct = (k < count / 3) ? 10 : ((k < 2 * count / 3) ? 62 : 0);
            r = $urandom_range(0, 99);
            if (r < 4)
                op = OP_BAD;
            else if (r < 36)
                op = OP_LOAD;
            else if (r < 68)
                op = OP_STORE;
            else
                op = OP_MODIFY;
            // small tag and set pools so lines get reused and evicted
            tg = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, nways + 2);
            set_i = ($urandom_range(0, 7) == 0) ? $urandom_range(0, set_max) :
                    $urandom_range(0, (set_max < 3) ? set_max : 3);
            if ($urandom_range(0, 9) == 0)
                addr = rand64();
            else
                addr = make_addr(tg, set_i, rand64());
            send(op, addr);
        end
    endtask

    initial
    begin
        chk = new();
        rst_n           = 1'b0;
        start           = 1'b0;
        req             = '0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        idle_cycles     = 0;
        items_accepted  = 0;
        sender_idle_pct = 0;
        settings_run    = 1;
        cur_sb          = 1;
        cur_bb          = 1;
        cur_ways        = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset geometry, one way: offset bit 0, set bit 1, tag above
        send(OP_LOAD,   64'h0);                    // fill
        send(OP_LOAD,   64'h1);                    // hit, other offset
        send(OP_STORE,  64'h4);                    // evict
        send(OP_LOAD,   64'h2);                    // fill set 1
        send(OP_MODIFY, 64'h0);                    // evict then hit
        send(OP_BAD,    64'hFFFF_FFFF_FFFF_FFFF);  // no state change
        send(OP_MODIFY, 64'h6);
        send(OP_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);
        send(OP_STORE,  64'hFFFF_FFFF_FFFF_FFFE);
        send(OP_LOAD,   64'h8000_0000_0000_0000);
        send(OP_BAD,    64'h0);
        drain();

        // Four ways in set 2: fill all, refresh the first, then two LRU evictions
        set_geometry(2, 2, 4);
        send(OP_LOAD,  64'h08);
        send(OP_LOAD,  64'h18);
        send(OP_LOAD,  64'h28);
        send(OP_STORE, 64'h38);
        send(OP_LOAD,  64'h08);
        send(OP_LOAD,  64'h48);
        send(OP_LOAD,  64'h18);
        drain();

        for (int g = 0; g < N_SETTINGS; g++) begin
            set_geometry(geo_sb[g], geo_bb[g], geo_ways[g]);
            random_run(ITEMS_PER_SETTING);
            drain();
        end
        repeat (8) @(posedge clk);

        $display("Ran %0d accesses across %0d register settings, idle and back-to-back.",
                 items_accepted, settings_run);
        $display("Checked %0d hits, %0d fills, %0d evictions, %0d bad ops; %0d errors.",
                 chk.outcome_seen[OUT_HIT], chk.outcome_seen[OUT_FILL],
                 chk.outcome_seen[OUT_EVICT], chk.outcome_seen[OUT_BAD], chk.errors);
        if (chk.errors == 0 && chk.expected_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
